@@ sv/eng_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// eng_pkg: shared types and constants for the envelope noise gate
// Holds the payload structs, the configuration struct, the register index
// codes and the fixed-point helper functions.
// ----------------------------------------------------------------------------
package eng_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 17;
    localparam int CFG_W    = 17;
    localparam int IDX_W    = 2;

    // Q1.16 unity and Q0.16 one tenth
    localparam logic [COEF_W-1:0] COEF_ONE  = COEF_W'(65536);
    localparam logic [12:0]       TENTH_Q16 = 13'd6554;

    // envelope full scale, Q1.15 magnitude of -1.0
    localparam logic [SAMPLE_W-1:0] ENV_FULL = SAMPLE_W'(1) << (SAMPLE_W - 1);

    localparam logic [SAMPLE_W-1:0] THRESHOLD_RST = SAMPLE_W'(328);
    localparam logic [COEF_W-1:0]   ATTACK_RST    = COEF_W'(6554);
    localparam logic [COEF_W-1:0]   RELEASE_RST   = COEF_W'(655);

    typedef enum logic [IDX_W-1:0] {
        REG_THRESHOLD = 2'd0,
        REG_ATTACK    = 2'd1,
        REG_RELEASE   = 2'd2
    } eng_reg_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic                       last_in;
    } eng_in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       gate_is_open;
        logic        [SAMPLE_W-1:0] envelope_level;
        logic                       last_out;
    } eng_out_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] open_level;
        logic [SAMPLE_W-1:0] close_level;
        logic [COEF_W-1:0]   attack;
        logic [COEF_W-1:0]   rel;
    } eng_cfg_t;

    // Close level: threshold * 6554 >> 16
    function automatic logic [SAMPLE_W-1:0] close_of(input logic [SAMPLE_W-1:0] thr);
        logic [SAMPLE_W+12:0] prod;
        prod = SAMPLE_W'(thr) * TENTH_Q16;
        return SAMPLE_W'(prod[SAMPLE_W+12:16]);
    endfunction

    // Limit a coefficient to unity
    function automatic logic [COEF_W-1:0] sat_coef(input logic [COEF_W-1:0] c);
        return (c > COEF_ONE) ? COEF_ONE : c;
    endfunction

endpackage
`default_nettype wire

@@ sv/eng_env_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// eng_env_core: envelope follower and hysteresis gate decision
// Pulls the envelope toward the sample magnitude with one shared multiply,
// clamps it and decides the gate state for the updated envelope.
// ----------------------------------------------------------------------------
module eng_env_core
    import eng_pkg::*;
(
    input  wire logic signed [SAMPLE_W-1:0] sample,
    input  wire logic        [SAMPLE_W-1:0] env_cur,
    input  wire logic                       gate_cur,
    input  wire eng_cfg_t                   cfg,
    output logic             [SAMPLE_W-1:0] env_new,
    output logic                            gate_new
);

    logic [SAMPLE_W-1:0]        mag;
    logic                       rising;
    logic [SAMPLE_W-1:0]        diff;
    logic [COEF_W-1:0]          coef;
    logic [COEF_W+SAMPLE_W-1:0] prod;
    logic [COEF_W-1:0]          step;
    logic [COEF_W:0]            env_sum;
    logic [COEF_W:0]            env_calc;

    // Magnitude: the most negative sample maps to full scale
    assign mag = sample[SAMPLE_W-1] ? SAMPLE_W'(-sample) : SAMPLE_W'(sample);

    // Pick direction, coefficient and distance
    assign rising = (mag > env_cur);
    assign diff   = rising ? (mag - env_cur) : (env_cur - mag);
    assign coef   = rising ? cfg.attack : cfg.rel;
    assign prod   = coef * diff;
    assign step   = prod[COEF_W+SAMPLE_W-1:16];

    // Apply the step, floor at zero
    always_comb begin
        if (rising) begin
            env_sum = (COEF_W+1)'(env_cur) + (COEF_W+1)'(step);
        end else if ((COEF_W+1)'(step) > (COEF_W+1)'(env_cur)) begin
            env_sum = '0;
        end else begin
            env_sum = (COEF_W+1)'(env_cur) - (COEF_W+1)'(step);
        end
    end

    // Clamp to full scale
    assign env_calc = (env_sum > (COEF_W+1)'(ENV_FULL)) ? (COEF_W+1)'(ENV_FULL) : env_sum;
    assign env_new  = env_calc[SAMPLE_W-1:0];

    // Open above threshold, close below one tenth, hold in between
    always_comb begin
        if (env_new > cfg.open_level) begin
            gate_new = 1'b1;
        end else if (env_new < cfg.close_level) begin
            gate_new = 1'b0;
        end else begin
            gate_new = gate_cur;
        end
    end

endmodule
`default_nettype wire

@@ sv/envelope_noise_gate.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// envelope_noise_gate: noise gate driven by an envelope follower
// Each request is one signed Q1.15 sample with a block-end mark; each
// produces one result with the gated sample, gate flag and envelope.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_valid/s_ready/s_data carries one sample per request.
//   Result channel m_valid/m_ready/m_data returns exactly one result per
//   request, in order. The block-end mark is copied to last_out.
//   Configuration: cfg_we writes cfg_wdata into the register selected by
//   cfg_index (0 threshold, 1 attack, 2 release); other indexes are ignored.
//   Write only while no request is in flight.
// Timing:
//   A sample is accepted into one input register, then the envelope update
//   (one 17x16 multiply, add, clamp, threshold compare) feeds the result
//   register. Throughput is one sample per cycle while m_ready is high.
// Reset:
//   aresetn low clears the envelope to zero, closes the gate, empties both
//   stages and restores the default coefficients and threshold.
// Stall:
//   When m_ready is low the result holds; one more request is taken into
//   the input register, then s_ready drops until the result is taken.
// ----------------------------------------------------------------------------
module envelope_noise_gate
    import eng_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire eng_in_t          s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output eng_out_t              m_data,
    input  wire logic             cfg_we,
    input  wire logic [IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0] cfg_wdata
);

    eng_cfg_t            cfg_reg, cfg_next;
    logic                in_valid_reg, in_valid_next;
    eng_in_t             in_reg, in_next;
    logic                out_valid_reg, out_valid_next;
    eng_out_t            out_reg, out_next;
    logic [SAMPLE_W-1:0] env_reg, env_next;
    logic                gate_reg, gate_next;

    logic                advance;
    logic                fire;
    logic [SAMPLE_W-1:0] env_upd;
    logic                gate_upd;

    // Configuration write: precompute close level and saturate coefficients
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_THRESHOLD: begin
                    cfg_next.open_level  = cfg_wdata[SAMPLE_W-1:0];
                    cfg_next.close_level = close_of(cfg_wdata[SAMPLE_W-1:0]);
                end
                REG_ATTACK: begin
                    cfg_next.attack = sat_coef(cfg_wdata[COEF_W-1:0]);
                end
                REG_RELEASE: begin
                    cfg_next.rel = sat_coef(cfg_wdata[COEF_W-1:0]);
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    // Handshake: advance when the result register is free or being drained
    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;
    assign fire    = in_valid_reg && advance;

    eng_env_core u_core (
        .sample   (in_reg.sample_in),
        .env_cur  (env_reg),
        .gate_cur (gate_reg),
        .cfg      (cfg_reg),
        .env_new  (env_upd),
        .gate_new (gate_upd)
    );

    // Input stage: take a request when there is room, drop it once used
    always_comb begin
        in_valid_next = in_valid_reg;
        in_next       = in_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
            in_next       = s_data;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    // Result stage and state update
    always_comb begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        env_next       = env_reg;
        gate_next      = gate_reg;
        if (fire) begin
            out_valid_next         = 1'b1;
            out_next.sample_out    = gate_upd ? in_reg.sample_in : '0;
            out_next.gate_is_open  = gate_upd;
            out_next.envelope_level = env_upd;
            out_next.last_out      = in_reg.last_in;
            env_next               = env_upd;
            gate_next              = gate_upd;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.open_level  <= THRESHOLD_RST;
            cfg_reg.close_level <= close_of(THRESHOLD_RST);
            cfg_reg.attack      <= ATTACK_RST;
            cfg_reg.rel         <= RELEASE_RST;
            in_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            env_reg             <= '0;
            gate_reg            <= 1'b0;
        end else begin
            cfg_reg       <= cfg_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            env_reg       <= env_next;
            gate_reg      <= gate_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        in_reg  <= in_next;
        out_reg <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

`ifndef SYNTHESIS
    a_env_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        env_reg <= ENV_FULL)
        else $error("envelope above full scale");

    a_closed_is_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.gate_is_open |-> m_data.sample_out == '0)
        else $error("closed gate passed a nonzero sample");

    a_result_matches_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.gate_is_open == gate_reg) && (m_data.envelope_level == env_reg))
        else $error("result does not match gate state");

    a_backpressure_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && out_valid_reg && !m_ready)
        else $error("input stalled with free room");
`endif

endmodule
`default_nettype wire

@@ verif/envelope_noise_gate_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// envelope_noise_gate_tb: self-checking bench for the envelope noise gate
// A directed table exercises the coefficient and threshold corners, then
// phases of random audio-like segments run under random settings. A local
// envelope model predicts each result that the table gives no literal for.
// ----------------------------------------------------------------------------
module envelope_noise_gate_tb;
    import eng_pkg::*;

    localparam logic [IDX_W-1:0] REG_NONE = 2'd3;  // unmapped index, ignored
    localparam int LATENCY     = 2;
    localparam int SETTLE      = LATENCY + 4;
    localparam int NPHASE      = 8;
    localparam int PHASE_ITEMS = 60;
    localparam int LONG_HOLD   = 150;

    typedef enum {ROW_CFG, ROW_SMP} row_kind_t;

    typedef struct {
        row_kind_t         kind;
        logic [IDX_W-1:0]  idx;
        logic [CFG_W-1:0]  val;
        eng_in_t           smp;
        bit                has_lit;
        eng_out_t          lit;
    } dir_row_t;

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    eng_in_t          s_data;
    logic             m_valid;
    logic             m_ready;
    eng_out_t         m_data;
    logic             cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_wdata;

    // model state and register copies
    logic [SAMPLE_W-1:0] env_st;
    bit                  gate_st;
    logic [SAMPLE_W-1:0] thr_st;
    logic [COEF_W-1:0]   att_st;
    logic [COEF_W-1:0]   rel_st;

    eng_out_t gated_q[$];
    dir_row_t dir_tab[$];
    int       err_count;
    bit       tx_idling;
    bit       rx_idling;
    bit       hold_req;

    envelope_noise_gate dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // Advance the envelope and gate by one sample and form its result
    function automatic eng_out_t gate_next(input eng_in_t d);
        longint unsigned mag;
        longint unsigned coef;
        longint unsigned dec;
        longint unsigned env;
        longint unsigned close_lvl;
        eng_out_t r;
        env = env_st;
        if (d.sample_in[SAMPLE_W-1]) begin
            mag = 64'h10000 - d.sample_in[SAMPLE_W-1:0];
        end else begin
            mag = d.sample_in[SAMPLE_W-1:0];
        end
        if (mag > env) begin
            coef = (att_st > COEF_ONE) ? COEF_ONE : att_st;
            env  = env + ((coef * (mag - env)) >> 16);
        end else begin
            coef = (rel_st > COEF_ONE) ? COEF_ONE : rel_st;
            dec  = (coef * (env - mag)) >> 16;
            env  = (dec > env) ? 0 : env - dec;
        end
        if (env > ENV_FULL) begin
            env = ENV_FULL;
        end
        // hysteresis: open above threshold, close below a tenth of it
        close_lvl = (thr_st * TENTH_Q16) >> 16;
        if (env > thr_st) begin
            gate_st = 1'b1;
        end else if (env < close_lvl) begin
            gate_st = 1'b0;
        end
        env_st           = env[SAMPLE_W-1:0];
        r.sample_out     = gate_st ? d.sample_in : '0;
        r.gate_is_open   = gate_st;
        r.envelope_level = env[SAMPLE_W-1:0];
        r.last_out       = d.last_in;
        return r;
    endfunction

    function automatic dir_row_t cfg_row(input logic [IDX_W-1:0] idx,
                                         input logic [CFG_W-1:0] val);
        dir_row_t r;
        r.kind    = ROW_CFG;
        r.idx     = idx;
        r.val     = val;
        r.smp     = '0;
        r.has_lit = 1'b0;
        r.lit     = '0;
        return r;
    endfunction

    function automatic dir_row_t smp_row(input logic signed [SAMPLE_W-1:0] smp,
                                         input bit lst, input bit has_lit,
                                         input eng_out_t lit);
        dir_row_t r;
        r.kind          = ROW_SMP;
        r.idx           = '0;
        r.val           = '0;
        r.smp.sample_in = smp;
        r.smp.last_in   = lst;
        r.has_lit       = has_lit;
        r.lit           = lit;
        return r;
    endfunction

    // Coefficient mix: zero, unity, above unity, slow, anywhere in range
    function automatic logic [CFG_W-1:0] pick_coef();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return COEF_ONE;
            2: return CFG_W'($urandom_range(65537, 131071));
            3: return CFG_W'($urandom_range(1, 4000));
            default: return CFG_W'($urandom_range(0, 65536));
        endcase
    endfunction

    // Offer one request, hold it until taken, then queue its expected result
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp, input bit lst,
                               input bit has_lit, input eng_out_t lit);
        eng_in_t  d;
        eng_out_t p;
        d.sample_in = smp;
        d.last_in   = lst;
        s_valid <= 1'b1;
        s_data  <= d;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        p = gate_next(d);
        gated_q.push_back(has_lit ? lit : p);
    endtask

    // Drop valid and wait until every result is back and the pipe is quiet
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (gated_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_THRESHOLD: thr_st = val[SAMPLE_W-1:0];
            REG_ATTACK:    att_st = val;
            REG_RELEASE:   rel_st = val;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // Receiver: random ready bursts, one long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (rx_idling && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
    end

    // Compare each taken result with the oldest pending one
    always @(posedge aclk) begin
        eng_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (gated_q.size() == 0) begin
                err_count++;
                if (err_count <= 10) begin
                    $display("unexpected result: sample %0d gate %0b env %0d last %0b",
                             m_data.sample_out, m_data.gate_is_open,
                             m_data.envelope_level, m_data.last_out);
                end
            end else begin
                want = gated_q.pop_front();
                if (m_data.sample_out !== want.sample_out ||
                    m_data.gate_is_open !== want.gate_is_open ||
                    m_data.envelope_level !== want.envelope_level ||
                    m_data.last_out !== want.last_out) begin
                    err_count++;
                    if (err_count <= 10) begin
                        $display("mismatch: sample %0d/%0d gate %0b/%0b env %0d/%0d last %0b/%0b",
                                 want.sample_out, m_data.sample_out,
                                 want.gate_is_open, m_data.gate_is_open,
                                 want.envelope_level, m_data.envelope_level,
                                 want.last_out, m_data.last_out);
                    end
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int                         ph;
        int                         n;
        int                         k;
        int                         seg_len;
        int                         mode;
        int                         v;
        bit                         lst;
        logic [CFG_W-1:0]           tv;
        logic signed [SAMPLE_W-1:0] smp;

        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        err_count = 0;
        tx_idling = 1'b0;
        rx_idling = 1'b0;
        hold_req  = 1'b0;
        env_st    = '0;
        gate_st   = 1'b0;
        thr_st    = THRESHOLD_RST;
        att_st    = ATTACK_RST;
        rel_st    = RELEASE_RST;

        // Corners: reset defaults, unity and oversized coefficients, zero and
        // out-of-range thresholds, unmapped index, threshold upper bit dropped
        dir_tab.push_back(smp_row(16'sd0, 1'b0, 1'b1, {16'h0000, 1'b0, 16'h0000, 1'b0}));
        dir_tab.push_back(smp_row(16'sd1, 1'b1, 1'b1, {16'h0000, 1'b0, 16'h0000, 1'b1}));
        dir_tab.push_back(cfg_row(REG_ATTACK, COEF_ONE));
        dir_tab.push_back(smp_row(16'sh8000, 1'b0, 1'b1, {16'h8000, 1'b1, 16'h8000, 1'b0}));
        dir_tab.push_back(smp_row(16'sh7FFF, 1'b1, 1'b0, '0));
        dir_tab.push_back(cfg_row(REG_RELEASE, COEF_ONE));
        dir_tab.push_back(smp_row(16'sd0, 1'b0, 1'b1, {16'h0000, 1'b0, 16'h0000, 1'b0}));
        dir_tab.push_back(cfg_row(REG_ATTACK, 17'h1FFFF));
        dir_tab.push_back(smp_row(16'sd100, 1'b0, 1'b0, '0));
        dir_tab.push_back(smp_row(-16'sd1000, 1'b0, 1'b0, '0));
        dir_tab.push_back(smp_row(16'sd5, 1'b1, 1'b0, '0));
        dir_tab.push_back(cfg_row(REG_RELEASE, 17'h1FFFF));
        dir_tab.push_back(smp_row(-16'sd1, 1'b0, 1'b0, '0));
        dir_tab.push_back(cfg_row(REG_THRESHOLD, 17'd0));
        dir_tab.push_back(smp_row(16'sd1, 1'b0, 1'b0, '0));
        dir_tab.push_back(smp_row(16'sd0, 1'b0, 1'b0, '0));
        dir_tab.push_back(cfg_row(REG_THRESHOLD, 17'd40000));
        dir_tab.push_back(smp_row(16'sh8000, 1'b0, 1'b0, '0));
        dir_tab.push_back(smp_row(16'sd0, 1'b0, 1'b0, '0));
        dir_tab.push_back(smp_row(16'sh8000, 1'b1, 1'b0, '0));
        dir_tab.push_back(cfg_row(REG_NONE, 17'h1FFFF));
        dir_tab.push_back(cfg_row(REG_THRESHOLD, 17'h10064));
        dir_tab.push_back(smp_row(16'sh7FFF, 1'b0, 1'b0, '0));
        dir_tab.push_back(cfg_row(REG_ATTACK, ATTACK_RST));
        dir_tab.push_back(cfg_row(REG_RELEASE, RELEASE_RST));
        dir_tab.push_back(cfg_row(REG_THRESHOLD, 17'd32768));
        dir_tab.push_back(smp_row(16'sh8000, 1'b1, 1'b0, '0));
        dir_tab.push_back(smp_row(16'sh8000, 1'b0, 1'b0, '0));

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Walk the directed table; settings change only with the pipe empty
        foreach (dir_tab[i]) begin
            if (dir_tab[i].kind == ROW_CFG) begin
                wait_idle();
                write_reg(dir_tab[i].idx, dir_tab[i].val);
            end else begin
                send_sample(dir_tab[i].smp.sample_in, dir_tab[i].smp.last_in,
                            dir_tab[i].has_lit, dir_tab[i].lit);
            end
        end

        // Random phases: new settings each phase, then audio-like segments
        for (ph = 0; ph < NPHASE; ph++) begin
            wait_idle();
            case ($urandom_range(0, 5))
                0: tv = '0;
                1: tv = CFG_W'(ENV_FULL);
                2: tv = CFG_W'($urandom_range(32769, 65535));
                3, 4: tv = CFG_W'($urandom_range(1, 2000));
                default: tv = CFG_W'($urandom_range(0, 131071));
            endcase
            write_reg(REG_THRESHOLD, tv);
            write_reg(REG_ATTACK, pick_coef());
            write_reg(REG_RELEASE, pick_coef());
            if ($urandom_range(0, 3) == 0) begin
                write_reg(REG_NONE, CFG_W'($urandom));
            end

            tx_idling = (ph != 0) && (ph != NPHASE - 1);
            rx_idling = tx_idling;
            if (ph == 2) begin
                hold_req = 1'b1;
            end

            n = 0;
            while (n < PHASE_ITEMS) begin
                seg_len = $urandom_range(4, 24);
                mode    = $urandom_range(0, 4);
                for (k = 0; k < seg_len && n < PHASE_ITEMS; k++) begin
                    case (mode)
                        0: v = int'($urandom_range(0, 65535)) - 32768;
                        1: v = int'($urandom_range(0, 40)) - 20;
                        2: v = int'($urandom_range(0, 6000)) - 3000;
                        3: begin
                            case ($urandom_range(0, 3))
                                0: v = -32768;
                                1: v = 32767;
                                2: v = -32767;
                                default: v = 1;
                            endcase
                        end
                        default: v = 0;
                    endcase
                    smp = SAMPLE_W'(v);
                    lst = (k == seg_len - 1) || ($urandom_range(0, 15) == 0);
                    if (tx_idling && $urandom_range(0, 3) == 0) begin
                        s_valid <= 1'b0;
                        repeat ($urandom_range(1, 12)) @(posedge aclk);
                    end
                    // pause the sender until the pipe has fully drained
                    if (ph == 4 && n == PHASE_ITEMS / 2) begin
                        s_valid <= 1'b0;
                        @(posedge aclk);
                        while (gated_q.size() != 0) @(posedge aclk);
                    end
                    send_sample(smp, lst, 1'b0, '0);
                    n++;
                end
            end
        end

        wait_idle();
        repeat (SETTLE) @(posedge aclk);
        if (err_count == 0 && gated_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
